@@ rtl/core/lpd_pkg.sv @@
package lpd_pkg;

   // Header is four length bytes (big-endian) plus one type byte
   localparam int unsigned HEADER_BYTES = 5;
   localparam logic [31:0] HEADER_LEN   = 32'(HEADER_BYTES);

   typedef enum logic [2:0] {
      POS_LEN0    = 3'd0,
      POS_LEN1    = 3'd1,
      POS_LEN2    = 3'd2,
      POS_LEN3    = 3'd3,
      POS_TYPE    = 3'd4,
      POS_PAYLOAD = 3'd5
   } hdr_pos_type;

   typedef struct packed {
      logic [7:0]  payload_byte;
      logic [7:0]  message_type;
      logic        has_data;
      logic        last_of_message;
      logic        length_error;
      logic [31:0] payload_length;
   } lpd_result_type;

endpackage

@@ rtl/core/lpd_in_stage.sv @@
module lpd_in_stage (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [7:0] req_in_byte,
   input  logic       out_free,
   output logic       req_stall,
   output logic       byte_valid,
   output logic [7:0] byte_data
);
   import lpd_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;
   logic       take;

   // The held byte leaves whenever the result side has room
   assign req_stall = valid_ff && !out_free;
   assign take      = req_valid && !req_stall;

   always_comb begin
      if (take) begin
         valid_in = 1'b1;
      end else if (out_free) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         byte_ff <= req_in_byte;
      end
   end

   assign byte_valid = valid_ff;
   assign byte_data  = byte_ff;

endmodule

@@ rtl/core/lpd_parser.sv @@
module lpd_parser (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    fire,
   input  logic [7:0]              in_byte,
   output logic                    emit,
   output lpd_pkg::lpd_result_type result
);
   import lpd_pkg::*;

   hdr_pos_type pos_ff, pos_in;
   logic [31:0] decl_len_ff, decl_len_in;
   logic [7:0]  type_ff, type_in;
   logic [31:0] remain_ff, remain_in;

   // Next state
   always_comb begin
      pos_in      = pos_ff;
      decl_len_in = decl_len_ff;
      type_in     = type_ff;
      remain_in   = remain_ff;
      case (pos_ff)
         POS_LEN0: begin
            decl_len_in = {24'd0, in_byte};
            pos_in      = POS_LEN1;
         end
         POS_LEN1: begin
            decl_len_in = {decl_len_ff[23:0], in_byte};
            pos_in      = POS_LEN2;
         end
         POS_LEN2: begin
            decl_len_in = {decl_len_ff[23:0], in_byte};
            pos_in      = POS_LEN3;
         end
         POS_LEN3: begin
            decl_len_in = {decl_len_ff[23:0], in_byte};
            pos_in      = POS_TYPE;
         end
         POS_TYPE: begin
            type_in = in_byte;
            if (decl_len_ff <= HEADER_LEN) begin
               remain_in = 32'd0;
               pos_in    = POS_LEN0;
            end else begin
               remain_in = decl_len_ff - HEADER_LEN;
               pos_in    = POS_PAYLOAD;
            end
         end
         POS_PAYLOAD: begin
            if (remain_ff <= 32'd1) begin
               remain_in = 32'd0;
               pos_in    = POS_LEN0;
            end else begin
               remain_in = remain_ff - 32'd1;
            end
         end
         default: begin
            // unreachable code: restart as first length byte
            decl_len_in = {24'd0, in_byte};
            pos_in      = POS_LEN1;
         end
      endcase
   end

   // Outputs
   always_comb begin
      emit                   = 1'b0;
      result.payload_byte    = 8'd0;
      result.message_type    = type_ff;
      result.has_data        = 1'b0;
      result.last_of_message = 1'b0;
      result.length_error    = 1'b0;
      result.payload_length  = 32'd0;
      case (pos_ff)
         POS_TYPE: begin
            result.message_type = in_byte;
            if (decl_len_ff <= HEADER_LEN) begin
               emit                   = 1'b1;
               result.last_of_message = 1'b1;
               result.length_error    = (decl_len_ff < HEADER_LEN);
            end
         end
         POS_PAYLOAD: begin
            emit                = 1'b1;
            result.payload_byte = in_byte;
            result.has_data     = 1'b1;
            if (remain_ff <= 32'd1) begin
               result.last_of_message = 1'b1;
               result.payload_length  = decl_len_ff - HEADER_LEN;
            end
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= POS_LEN0;
         decl_len_ff <= 32'd0;
         type_ff     <= 8'd0;
         remain_ff   <= 32'd0;
      end else if (fire) begin
         pos_ff      <= pos_in;
         decl_len_ff <= decl_len_in;
         type_ff     <= type_in;
         remain_ff   <= remain_in;
      end
   end

endmodule

@@ rtl/core/lpd_out_stage.sv @@
module lpd_out_stage (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  lpd_pkg::lpd_result_type result,
   input  logic                    rsp_stall,
   output logic                    out_free,
   output logic                    rsp_valid,
   output lpd_pkg::lpd_result_type rsp_data
);
   import lpd_pkg::*;

   logic           valid_ff;
   logic           valid_in;
   lpd_result_type data_ff;

   // Free when empty or when the held result leaves this edge
   assign out_free = !valid_ff || !rsp_stall;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

@@ rtl/core/length_prefixed_deframer.sv @@
// Channel   Direction  Handshake             Payload
// req       in         req_valid/req_stall   req_in_byte[7:0]
// rsp       out        rsp_valid/rsp_stall   payload byte, type, flags, payload length[31:0]
//
// One byte is taken per cycle while req_stall is low; each byte is held in the input register,
// and its result, if any, is loaded into the result register when the parser consumes it.
// The rate is set by the parser's single pass: the header position, length and
// remaining count all update in the cycle the held byte is consumed.
// Reset (synchronous, active high) returns the parser to the first length byte
// and empties both the input and result registers.
// A stall on rsp holds the result register and, once the input register is also
// full, raises req_stall in the same cycle.
module length_prefixed_deframer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_payload_byte,
   output logic [7:0]  rsp_message_type,
   output logic        rsp_has_data,
   output logic        rsp_last_of_message,
   output logic        rsp_length_error,
   output logic [31:0] rsp_payload_length
);
   import lpd_pkg::*;

   logic           out_free;
   logic           byte_valid;
   logic [7:0]     byte_data;
   logic           fire;
   logic           emit;
   lpd_result_type result;
   lpd_result_type rsp_data;

   // Hold the received byte until the parser consumes it
   lpd_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_in_byte(req_in_byte),
      .out_free   (out_free),
      .req_stall  (req_stall),
      .byte_valid (byte_valid),
      .byte_data  (byte_data)
   );

   // Advance the parser only when its result, if any, has a place to go
   assign fire = byte_valid && out_free;

   lpd_parser u_parser (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .in_byte(byte_data),
      .emit   (emit),
      .result (result)
   );

   // Only emitting bytes load the result register; other header bytes drop out here
   lpd_out_stage u_out (
      .clock    (clock),
      .reset    (reset),
      .load     (fire && emit),
      .result   (result),
      .rsp_stall(rsp_stall),
      .out_free (out_free),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   assign rsp_payload_byte    = rsp_data.payload_byte;
   assign rsp_message_type    = rsp_data.message_type;
   assign rsp_has_data        = rsp_data.has_data;
   assign rsp_last_of_message = rsp_data.last_of_message;
   assign rsp_length_error    = rsp_data.length_error;
   assign rsp_payload_length  = rsp_data.payload_length;

endmodule

@@ rtl/core/lpd_checker.sv @@
module lpd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [7:0]  rsp_payload_byte,
   input logic [7:0]  rsp_message_type,
   input logic        rsp_has_data,
   input logic        rsp_last_of_message,
   input logic        rsp_length_error,
   input logic [31:0] rsp_payload_length
);
   import lpd_pkg::*;

   // A stalled result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload_byte)
         && $stable(rsp_message_type) && $stable(rsp_payload_length))
      else $error("stalled result changed");

   // Only a closing result carries a payload length
   a_len_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_of_message |-> rsp_payload_length == 32'd0)
      else $error("payload length outside last result");

   // A data-less result closes a header-only message
   a_nodata_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_has_data |-> rsp_last_of_message && rsp_payload_byte == 8'd0
         && rsp_payload_length == 32'd0)
      else $error("bad header-only result");

   // A length error never comes with payload
   a_err_nodata: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_length_error |-> !rsp_has_data)
      else $error("length error with data");

   // The input stalls only behind a full, stalled result register
   a_req_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without result back-pressure");

endmodule

bind length_prefixed_deframer lpd_checker u_lpd_checker (
   .clock              (clock),
   .reset              (reset),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_payload_byte   (rsp_payload_byte),
   .rsp_message_type   (rsp_message_type),
   .rsp_has_data       (rsp_has_data),
   .rsp_last_of_message(rsp_last_of_message),
   .rsp_length_error   (rsp_length_error),
   .rsp_payload_length (rsp_payload_length)
);
